### design/rtwf_pkg.sv
// Shared types and constants for the route time-window feasibility core.
package rtwf_pkg;

  // Depot store depth and the index width that addresses it
  localparam int unsigned NUM_DEPOTS = 16;
  localparam int unsigned DIDX_W     = (NUM_DEPOTS > 1) ? $clog2(NUM_DEPOTS) : 1;
  // Wide enough to hold any depot_index value and NUM_DEPOTS itself
  localparam int unsigned DEXT_W     = 9;

  localparam logic [23:0] CAP_RESET  = 24'hFF_FFFF;

  // One vertex visit as captured from the input channel
  typedef struct packed {
    logic [3:0]  depot_index;
    logic        route_start;
    logic        route_end;
    logic        is_depot;
    logic [31:0] travel_time;
    logic [31:0] window_open;
    logic [31:0] window_close;
    logic [15:0] demand;
    logic [23:0] depot_capacity;
    logic [7:0]  depot_vehicle_limit;
    logic        solution_end;
  } item_t;

  // Route totals and verdict for the vertex in the work stage
  typedef struct packed {
    logic [23:0] load;
    logic [31:0] finish;
    logic [31:0] length;
    logic        fault;
    logic        is_end;
    logic        sol_end;
  } route_res_t;

endpackage

### design/rtwf_route.sv
// Per-route arrival, load and length accumulation with route rule checks.
module rtwf_route (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  rtwf_pkg::item_t     item_i,
  input  logic [23:0]         vehicle_capacity_i,
  output rtwf_pkg::route_res_t res_o
);
  import rtwf_pkg::*;

  logic [31:0] arr_q, arr_d;
  logic [23:0] load_q, load_d;
  logic [31:0] len_q, len_d;
  logic        fault_q, fault_d;

  logic [32:0] arr_sum;
  logic [32:0] len_sum;
  logic [24:0] load_sum;
  logic [31:0] arr_n;
  logic [23:0] load_n;
  logic [31:0] len_n;
  logic        fault_n;
  logic        late;
  logic        is_end;
  logic        fault_fin;

  // Step the route state by one vertex
  always_comb begin
    arr_sum  = {1'b0, arr_q} + {1'b0, item_i.travel_time};
    len_sum  = {1'b0, len_q} + {1'b0, item_i.travel_time};
    load_sum = {1'b0, load_q} + {9'd0, item_i.demand};
    late     = 1'b0;
    arr_n    = arr_q;
    load_n   = load_q;
    len_n    = len_q;
    fault_n  = fault_q;
    if (item_i.route_start) begin
      arr_n   = item_i.window_open;
      load_n  = '0;
      len_n   = '0;
      fault_n = !item_i.is_depot;
    end else begin
      // Arrival saturates on overflow and then counts as late
      late  = arr_sum[32];
      arr_n = arr_sum[32] ? 32'hFFFF_FFFF : arr_sum[31:0];
      if (arr_n < item_i.window_open) begin
        arr_n = item_i.window_open;
      end
      if (arr_n > item_i.window_close) begin
        late = 1'b1;
      end
      len_n = len_sum[32] ? 32'hFFFF_FFFF : len_sum[31:0];
      if (late) begin
        fault_n = 1'b1;
      end
      if (!item_i.is_depot) begin
        if (load_sum[24]) begin
          load_n  = 24'hFF_FFFF;
          fault_n = 1'b1;
        end else begin
          load_n = load_sum[23:0];
        end
      end
    end
  end

  // Route-end checks: must end at a depot, must not be overloaded
  assign is_end    = item_i.route_end | item_i.solution_end;
  assign fault_fin = fault_n | !item_i.is_depot | (load_n > vehicle_capacity_i);

  assign res_o = '{load:    load_n,
                   finish:  arr_n,
                   length:  len_n,
                   fault:   is_end ? fault_fin : fault_n,
                   is_end:  is_end,
                   sol_end: item_i.solution_end};

  // Route state clears after every route end
  always_comb begin
    arr_d   = arr_q;
    load_d  = load_q;
    len_d   = len_q;
    fault_d = fault_q;
    if (fire_i) begin
      if (is_end) begin
        arr_d   = '0;
        load_d  = '0;
        len_d   = '0;
        fault_d = 1'b0;
      end else begin
        arr_d   = arr_n;
        load_d  = load_n;
        len_d   = len_n;
        fault_d = fault_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arr_q   <= '0;
      load_q  <= '0;
      len_q   <= '0;
      fault_q <= 1'b0;
    end else begin
      arr_q   <= arr_d;
      load_q  <= load_d;
      len_q   <= len_d;
      fault_q <= fault_d;
    end
  end

endmodule

### design/rtwf_depot.sv
// Per-depot load and vehicle totals with solution-level fault tracking.
module rtwf_depot (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   fire_i,
  input  rtwf_pkg::item_t        item_i,
  input  rtwf_pkg::route_res_t   route_i,
  output logic                   sol_fault_o
);
  import rtwf_pkg::*;

  logic [23:0]       dload_q [NUM_DEPOTS];
  logic [7:0]        dveh_q  [NUM_DEPOTS];
  logic [NUM_DEPOTS-1:0] dvld_q;
  logic              sfault_q;

  logic [DEXT_W-1:0] dix_ext;
  logic [DIDX_W-1:0] slot;
  logic              in_range;
  logic [23:0]       cur_load;
  logic [7:0]        cur_veh;
  logic [24:0]       dl_sum;
  logic [8:0]        dv_sum;
  logic [23:0]       dl_new;
  logic [7:0]        dv_new;
  logic              sfault_fin;
  logic              do_upd;

  assign dix_ext  = {{(DEXT_W-4){1'b0}}, item_i.depot_index};
  assign slot     = dix_ext[DIDX_W-1:0];
  assign in_range = dix_ext < DEXT_W'(NUM_DEPOTS);

  // Entries not written since the last clear read as zero
  assign cur_load = (in_range && dvld_q[slot]) ? dload_q[slot] : '0;
  assign cur_veh  = (in_range && dvld_q[slot]) ? dveh_q[slot]  : '0;

  // Add the finished route into its depot and check the depot limits
  always_comb begin
    dl_sum     = {1'b0, cur_load} + {1'b0, route_i.load};
    dv_sum     = {1'b0, cur_veh} + 9'd1;
    dl_new     = dl_sum[24] ? 24'hFF_FFFF : dl_sum[23:0];
    dv_new     = dv_sum[8] ? 8'hFF : dv_sum[7:0];
    sfault_fin = sfault_q | route_i.fault;
    if (in_range) begin
      if (dl_sum[24] || (dl_new > item_i.depot_capacity)) begin
        sfault_fin = 1'b1;
      end
      if (dv_sum[8] || (dv_new > item_i.depot_vehicle_limit)) begin
        sfault_fin = 1'b1;
      end
    end else begin
      sfault_fin = 1'b1;
    end
  end

  assign sol_fault_o = sfault_fin;
  assign do_upd      = fire_i & route_i.is_end;

  // Entry payload
  always_ff @(posedge clk_i) begin
    if (do_upd && in_range) begin
      dload_q[slot] <= dl_new;
      dveh_q[slot]  <= dv_new;
    end
  end

  // Valid bits and solution fault; a solution end clears the store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvld_q   <= '0;
      sfault_q <= 1'b0;
    end else if (do_upd) begin
      if (route_i.sol_end) begin
        dvld_q   <= '0;
        sfault_q <= 1'b0;
      end else begin
        if (in_range) begin
          dvld_q[slot] <= 1'b1;
        end
        sfault_q <= sfault_fin;
      end
    end
  end

endmodule

### design/route_time_window_feasibility_core.sv
// Top level of the route time-window feasibility core.
//
// Input channel (in_valid_i / in_ready_o) carries one route vertex visit per
// transaction. Output channel (out_valid_o / out_ready_i) carries one result
// transaction for each vertex that ends a route (route_end or solution_end);
// other vertices produce nothing.
// A vertex is captured in an input register, evaluated in the work stage
// against the route and depot state, and its result lands in the output
// register, which drives out_valid_o. Throughput is one vertex per cycle
// while the output is not stalled; the route and depot state update is a
// single-cycle loop around the work stage. When the receiver stalls with a
// result held, the work stage holds a route-end vertex until the output
// register frees up; vertices without a result keep flowing. in_ready_o
// follows out_ready_i combinationally. vehicle_capacity is to be written
// through cfg_we_i / cfg_wdata_i while idle; the core does not enforce it.
// Reset clears route state, depot totals, the solution fault flag and both
// pipeline valid bits, and sets vehicle_capacity to its maximum.
module route_time_window_feasibility_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [23:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  depot_index_i,
  input  logic        route_start_i,
  input  logic        route_end_i,
  input  logic        is_depot_i,
  input  logic [31:0] travel_time_i,
  input  logic [31:0] window_open_i,
  input  logic [31:0] window_close_i,
  input  logic [15:0] demand_i,
  input  logic [23:0] depot_capacity_i,
  input  logic [7:0]  depot_vehicle_limit_i,
  input  logic        solution_end_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [23:0] route_load_o,
  output logic [31:0] route_finish_time_o,
  output logic [31:0] route_length_o,
  output logic        route_valid_o,
  output logic        solution_feasible_o,
  output logic        solution_done_o
);
  import rtwf_pkg::*;

  logic [23:0] vcap_q;
  item_t       s1_q;
  logic        s1_vld_q;
  logic        out_vld_q;
  logic [23:0] o_load_q;
  logic [31:0] o_finish_q;
  logic [31:0] o_length_q;
  logic        o_rvalid_q;
  logic        o_feas_q;
  logic        o_done_q;

  route_res_t  route_res;
  logic        sol_fault;
  logic        out_free;
  logic        advance;
  logic        in_acc;
  logic        s1_load;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcap_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      vcap_q <= cfg_wdata_i;
    end
  end

  // Handshake: work stage moves on unless its result has nowhere to go
  assign out_free   = !out_vld_q | out_ready_i;
  assign advance    = s1_vld_q & (!route_res.is_end | out_free);
  assign in_ready_o = !s1_vld_q | advance;
  assign in_acc     = in_valid_i & in_ready_o;
  assign s1_load    = in_acc;

  // Input register
  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_q <= '{depot_index:         depot_index_i,
                route_start:         route_start_i,
                route_end:           route_end_i,
                is_depot:            is_depot_i,
                travel_time:         travel_time_i,
                window_open:         window_open_i,
                window_close:        window_close_i,
                demand:              demand_i,
                depot_capacity:      depot_capacity_i,
                depot_vehicle_limit: depot_vehicle_limit_i,
                solution_end:        solution_end_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_vld_q <= in_valid_i;
    end
  end

  rtwf_route u_route (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .fire_i             (advance),
    .item_i             (s1_q),
    .vehicle_capacity_i (vcap_q),
    .res_o              (route_res)
  );

  rtwf_depot u_depot (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (advance),
    .item_i      (s1_q),
    .route_i     (route_res),
    .sol_fault_o (sol_fault)
  );

  // Output register
  always_ff @(posedge clk_i) begin
    if (advance && route_res.is_end) begin
      o_load_q   <= route_res.load;
      o_finish_q <= route_res.finish;
      o_length_q <= route_res.length;
      o_rvalid_q <= !route_res.fault;
      o_feas_q   <= !sol_fault;
      o_done_q   <= route_res.sol_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance && route_res.is_end) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  assign out_valid_o         = out_vld_q;
  assign route_load_o        = o_load_q;
  assign route_finish_time_o = o_finish_q;
  assign route_length_o      = o_length_q;
  assign route_valid_o       = o_rvalid_q;
  assign solution_feasible_o = o_feas_q;
  assign solution_done_o     = o_done_q;

endmodule
